// ===== design/slcm_pkg.sv =====
// Shared constants for the skew line closest midpoint pipeline.
// Used by slcm_mul, slcm_div and skew_line_closest_midpoint; no dependencies.
package slcm_pkg;

	localparam int CW      = 32;
	localparam int MA_W    = 136;
	localparam int MB_W    = 66;
	localparam int MP_W    = 202;
	localparam int MUL_LAT = 6;
	localparam int QB      = 34;
	localparam int DIV_W   = 164;
	localparam int DIV_LAT = QB + 1;
	localparam int LAT     = 3 + MUL_LAT + 2 + MUL_LAT + 3 + DIV_LAT + 1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DEGEN = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	localparam logic signed [35:0] R_MAX = 36'sd2147483647;
	localparam logic signed [35:0] R_MIN = -36'sd2147483648;

	typedef logic signed [CW-1:0] crd_t;

endpackage

// ===== design/slcm_mul.sv =====
// Pipelined signed multiplier, 136 x 66 bits, built from 32x32 partial products.
// Registered pipeline, advances on en. Depends on slcm_pkg.
module slcm_mul import slcm_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [MA_W-1:0] a,
	input  logic signed [MB_W-1:0] b,
	output logic signed [MP_W-1:0] prod
);

	localparam int MA_D = 5;
	localparam int MB_D = 3;

	logic [MA_W-1:0]    abs_a;
	logic [MB_W-1:0]    abs_b;
	logic [32*MA_D-1:0] ma_s1;
	logic [32*MB_D-1:0] mb_s1;
	logic               neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [63:0]        pp_s2 [MA_D][MB_D];
	logic [191:0]       row_s3 [MB_D];
	logic [223:0]       sum01_s4;
	logic [191:0]       row2_s4;
	logic [255:0]       sum_s5;
	logic signed [MP_W-1:0] prod_s6;

	assign abs_a = a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
	assign abs_b = b[MB_W-1] ? MB_W'(-b) : MB_W'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= {{(32*MA_D-MA_W){1'b0}}, abs_a};
			mb_s1  <= {{(32*MB_D-MB_W){1'b0}}, abs_b};
			neg_s1 <= a[MA_W-1] ^ b[MB_W-1];
			for (int i = 0; i < MA_D; i++) begin
				for (int j = 0; j < MB_D; j++) begin
					pp_s2[i][j] <= ma_s1[32*i +: 32] * mb_s1[32*j +: 32];
				end
			end
			neg_s2 <= neg_s1;
			for (int j = 0; j < MB_D; j++) begin
				row_s3[j] <= {pp_s2[4][j], pp_s2[2][j], pp_s2[0][j]}
					+ {32'b0, pp_s2[3][j], pp_s2[1][j], 32'b0};
			end
			neg_s3   <= neg_s2;
			sum01_s4 <= {32'b0, row_s3[0]} + {row_s3[1], 32'b0};
			row2_s4  <= row_s3[2];
			neg_s4   <= neg_s3;
			sum_s5   <= {32'b0, sum01_s4} + {row2_s4, 64'b0};
			neg_s5   <= neg_s4;
			prod_s6  <= neg_s5 ? MP_W'(-sum_s5[MP_W-1:0]) : sum_s5[MP_W-1:0];
		end
	end

	assign prod = prod_s6;

endmodule

// ===== design/slcm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Advances on en. Depends on slcm_pkg.
module slcm_div import slcm_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [DIV_W-1:0] y,
	input  logic [DIV_W-1:0] dv,
	output logic [QB-1:0]    q,
	output logic             ovf
);

	logic [DIV_W-1:0] rem_s [QB+1];
	logic [DIV_W-1:0] dv_s  [QB+1];
	logic [QB-1:0]    q_s   [QB+1];
	logic             ovf_s [QB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= (y >= (dv << QB));
			rem_s[0] <= y;
			dv_s[0]  <= dv;
			q_s[0]   <= '0;
		end
	end

	for (genvar t = 1; t <= QB; t++) begin : g_bit
		logic [DIV_W-1:0] sh;
		logic             ge;
		assign sh = dv_s[t-1] << (QB - t);
		assign ge = rem_s[t-1] >= sh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[t] <= ge ? rem_s[t-1] - sh : rem_s[t-1];
				q_s[t]   <= q_s[t-1] | (QB'(ge) << (QB - t));
				dv_s[t]  <= dv_s[t-1];
				ovf_s[t] <= ovf_s[t-1];
			end
		end
	end

	assign q   = q_s[QB];
	assign ovf = ovf_s[QB];

endmodule

// ===== design/skew_line_closest_midpoint.sv =====
// Top level: midpoint of the common perpendicular of two 3D lines, Q16.16.
// Depends on slcm_pkg, slcm_mul and slcm_div.
//
// Input channel line_*: a point and a direction for each of two lines, taken
// when line_valid is high and line_stall is low. Output channel mid_*: the
// midpoint and a status (ok, parallel or zero direction, saturated), taken
// when mid_valid is high and mid_stall is low.
// One word in, one word out, in order. The pipeline runs cross products, two
// multiplier banks, sums and rounding prep, and a divider that resolves one
// quotient bit per stage.
// Throughput is one word per cycle while the output is not stalled.
// Reset clears only the valid bits; the pipeline is empty after reset.
// When the output word is stalled the whole pipeline holds and line_stall
// rises in the same cycle; nothing is dropped or repeated. Bubbles fill in
// while the output is empty.
module skew_line_closest_midpoint import slcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        line_valid,
	output logic        line_stall,
	input  crd_t        line_a_point_x,
	input  crd_t        line_a_point_y,
	input  crd_t        line_a_point_z,
	input  crd_t        line_a_dir_x,
	input  crd_t        line_a_dir_y,
	input  crd_t        line_a_dir_z,
	input  crd_t        line_b_point_x,
	input  crd_t        line_b_point_y,
	input  crd_t        line_b_point_z,
	input  crd_t        line_b_dir_x,
	input  crd_t        line_b_dir_y,
	input  crd_t        line_b_dir_z,
	output logic        mid_valid,
	input  logic        mid_stall,
	output crd_t        mid_x,
	output crd_t        mid_y,
	output crd_t        mid_z,
	output logic [1:0]  status
);

	logic           en;
	logic [LAT-1:0] vld_q;

	crd_t pa [3];
	crd_t da [3];
	crd_t pb [3];
	crd_t db [3];

	crd_t              A_s1 [3];
	crd_t              a_s1 [3];
	crd_t              b_s1 [3];
	logic signed [32:0] d_s1 [3];

	crd_t              A_s2 [3];
	crd_t              a_s2 [3];
	logic signed [32:0] d_s2 [3];
	logic signed [63:0] na_s2 [3];
	logic signed [63:0] nb_s2 [3];
	logic signed [64:0] ma_s2 [3];
	logic signed [64:0] mb_s2 [3];

	crd_t              A_s3 [3];
	crd_t              a_s3 [3];
	logic signed [32:0] d_s3 [3];
	logic signed [64:0] n_s3 [3];
	logic signed [65:0] m_s3 [3];

	crd_t               A_d1 [MUL_LAT][3];
	crd_t               a_d1 [MUL_LAT][3];
	logic signed [64:0] n_d1 [MUL_LAT][3];

	logic signed [MP_W-1:0] mn_p [3];
	logic signed [MP_W-1:0] dn_p [3];
	logic signed [MP_W-1:0] nn_p [3];

	crd_t                A_s10 [3];
	crd_t                a_s10 [3];
	logic signed [64:0]  n_s10 [3];
	logic signed [131:0] s01_s10, s2_s10;
	logic signed [99:0]  p01_s10, p2_s10;
	logic signed [129:0] nn01_s10, nn2_s10;

	crd_t                A_s11 [3];
	crd_t                a_s11 [3];
	logic signed [64:0]  n_s11 [3];
	logic signed [131:0] s_s11;
	logic signed [99:0]  p_s11;
	logic signed [129:0] nn_s11;
	logic signed [MA_W-1:0] s2x;

	crd_t                A_d2  [MUL_LAT][3];
	logic signed [129:0] nn_d2 [MUL_LAT];

	logic signed [MP_W-1:0] sa_p [3];
	logic signed [MP_W-1:0] pn_p [3];

	crd_t                A_s18 [3];
	logic signed [129:0] nn_s18;
	logic signed [DIV_W-1:0] num_s18 [3];

	crd_t                A_s19 [3];
	logic signed [129:0] nn_s19;
	logic [DIV_W-1:0]    mag_s19 [3];
	logic                neg_s19 [3];

	crd_t             A_s20 [3];
	logic             neg_s20 [3];
	logic             dz_s20;
	logic [DIV_W-1:0] y_s20 [3];
	logic [DIV_W-1:0] dv_s20;

	crd_t A_d3   [DIV_LAT][3];
	logic neg_d3 [DIV_LAT][3];
	logic dz_d3  [DIV_LAT];

	logic [QB-1:0] q_o   [3];
	logic          ovf_o [3];

	logic signed [35:0] r_c   [3];
	crd_t               res_c [3];
	logic [2:0]         sat_c;

	crd_t       mid_s56 [3];
	logic [1:0] st_s56;

	assign pa[0] = line_a_point_x;
	assign pa[1] = line_a_point_y;
	assign pa[2] = line_a_point_z;
	assign da[0] = line_a_dir_x;
	assign da[1] = line_a_dir_y;
	assign da[2] = line_a_dir_z;
	assign pb[0] = line_b_point_x;
	assign pb[1] = line_b_point_y;
	assign pb[2] = line_b_point_z;
	assign db[0] = line_b_dir_x;
	assign db[1] = line_b_dir_y;
	assign db[2] = line_b_dir_z;

	assign en         = !(vld_q[LAT-1] && mid_stall);
	assign line_stall = !en;
	assign mid_valid  = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], line_valid};
		end
	end

	// d = C - A, cross products n = a x b and m = d x b
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				A_s1[k] <= pa[k];
				a_s1[k] <= da[k];
				b_s1[k] <= db[k];
				d_s1[k] <= 33'(pb[k]) - 33'(pa[k]);
			end
			for (int k = 0; k < 3; k++) begin
				na_s2[k] <= a_s1[(k+1)%3] * b_s1[(k+2)%3];
				nb_s2[k] <= a_s1[(k+2)%3] * b_s1[(k+1)%3];
				ma_s2[k] <= 65'(d_s1[(k+1)%3]) * 65'(b_s1[(k+2)%3]);
				mb_s2[k] <= 65'(d_s1[(k+2)%3]) * 65'(b_s1[(k+1)%3]);
				A_s2[k]  <= A_s1[k];
				a_s2[k]  <= a_s1[k];
				d_s2[k]  <= d_s1[k];
			end
			for (int k = 0; k < 3; k++) begin
				n_s3[k] <= 65'(na_s2[k]) - 65'(nb_s2[k]);
				m_s3[k] <= 66'(ma_s2[k]) - 66'(mb_s2[k]);
				A_s3[k] <= A_s2[k];
				a_s3[k] <= a_s2[k];
				d_s3[k] <= d_s2[k];
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_mul1
		slcm_mul u_mn (.clk(clk), .en(en), .a(MA_W'(m_s3[k])), .b(MB_W'(n_s3[k])),
			.prod(mn_p[k]));
		slcm_mul u_dn (.clk(clk), .en(en), .a(MA_W'(n_s3[k])), .b(MB_W'(d_s3[k])),
			.prod(dn_p[k]));
		slcm_mul u_nn (.clk(clk), .en(en), .a(MA_W'(n_s3[k])), .b(MB_W'(n_s3[k])),
			.prod(nn_p[k]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			A_d1[0] <= A_s3;
			a_d1[0] <= a_s3;
			n_d1[0] <= n_s3;
			for (int t = 1; t < MUL_LAT; t++) begin
				A_d1[t] <= A_d1[t-1];
				a_d1[t] <= a_d1[t-1];
				n_d1[t] <= n_d1[t-1];
			end
		end
	end

	// s = (d x b).n, p = d.n, nn = n.n
	always_ff @(posedge clk) begin
		if (en) begin
			A_s10    <= A_d1[MUL_LAT-1];
			a_s10    <= a_d1[MUL_LAT-1];
			n_s10    <= n_d1[MUL_LAT-1];
			s01_s10  <= 132'(mn_p[0]) + 132'(mn_p[1]);
			s2_s10   <= 132'(mn_p[2]);
			p01_s10  <= 100'(dn_p[0]) + 100'(dn_p[1]);
			p2_s10   <= 100'(dn_p[2]);
			nn01_s10 <= 130'(nn_p[0]) + 130'(nn_p[1]);
			nn2_s10  <= 130'(nn_p[2]);
			A_s11    <= A_s10;
			a_s11    <= a_s10;
			n_s11    <= n_s10;
			s_s11    <= s01_s10 + s2_s10;
			p_s11    <= p01_s10 + p2_s10;
			nn_s11   <= nn01_s10 + nn2_s10;
		end
	end

	assign s2x = MA_W'(s_s11) <<< 1;

	for (genvar k = 0; k < 3; k++) begin : g_mul2
		slcm_mul u_sa (.clk(clk), .en(en), .a(s2x), .b(MB_W'(a_s11[k])),
			.prod(sa_p[k]));
		slcm_mul u_pn (.clk(clk), .en(en), .a(MA_W'(p_s11)), .b(MB_W'(n_s11[k])),
			.prod(pn_p[k]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			A_d2[0]  <= A_s11;
			nn_d2[0] <= nn_s11;
			for (int t = 1; t < MUL_LAT; t++) begin
				A_d2[t]  <= A_d2[t-1];
				nn_d2[t] <= nn_d2[t-1];
			end
		end
	end

	// numerator, magnitude, rounding bias
	always_ff @(posedge clk) begin
		if (en) begin
			A_s18  <= A_d2[MUL_LAT-1];
			nn_s18 <= nn_d2[MUL_LAT-1];
			for (int k = 0; k < 3; k++) begin
				num_s18[k] <= DIV_W'(sa_p[k]) + DIV_W'(pn_p[k]);
			end
			A_s19  <= A_s18;
			nn_s19 <= nn_s18;
			for (int k = 0; k < 3; k++) begin
				neg_s19[k] <= num_s18[k][DIV_W-1];
				mag_s19[k] <= num_s18[k][DIV_W-1] ? DIV_W'(-num_s18[k]) : DIV_W'(num_s18[k]);
			end
			A_s20   <= A_s19;
			neg_s20 <= neg_s19;
			dz_s20  <= (nn_s19 == '0);
			dv_s20  <= DIV_W'($unsigned(nn_s19)) << 1;
			for (int k = 0; k < 3; k++) begin
				y_s20[k] <= mag_s19[k] + DIV_W'($unsigned(nn_s19));
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_div
		slcm_div u_div (.clk(clk), .en(en), .y(y_s20[k]), .dv(dv_s20),
			.q(q_o[k]), .ovf(ovf_o[k]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			A_d3[0]   <= A_s20;
			neg_d3[0] <= neg_s20;
			dz_d3[0]  <= dz_s20;
			for (int t = 1; t < DIV_LAT; t++) begin
				A_d3[t]   <= A_d3[t-1];
				neg_d3[t] <= neg_d3[t-1];
				dz_d3[t]  <= dz_d3[t-1];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			r_c[k] = 36'(A_d3[DIV_LAT-1][k])
				+ (neg_d3[DIV_LAT-1][k] ? -36'(q_o[k]) : 36'(q_o[k]));
			if (ovf_o[k]) begin
				res_c[k] = neg_d3[DIV_LAT-1][k] ? CW'(R_MIN) : CW'(R_MAX);
				sat_c[k] = 1'b1;
			end else if (r_c[k] > R_MAX) begin
				res_c[k] = CW'(R_MAX);
				sat_c[k] = 1'b1;
			end else if (r_c[k] < R_MIN) begin
				res_c[k] = CW'(R_MIN);
				sat_c[k] = 1'b1;
			end else begin
				res_c[k] = CW'(r_c[k]);
				sat_c[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dz_d3[DIV_LAT-1]) begin
				for (int k = 0; k < 3; k++) mid_s56[k] <= '0;
				st_s56 <= ST_DEGEN;
			end else begin
				mid_s56 <= res_c;
				st_s56  <= (|sat_c) ? ST_SAT : ST_OK;
			end
		end
	end

	assign mid_x  = mid_s56[0];
	assign mid_y  = mid_s56[1];
	assign mid_z  = mid_s56[2];
	assign status = st_s56;

endmodule

// ===== bench/skew_line_closest_midpoint_tb.sv =====
// Testbench for skew_line_closest_midpoint: directed and random line pairs with random idling.
// Results are predicted with wide integer math and checked in order; needs slcm_pkg.
`timescale 1ns / 1ps

module skew_line_closest_midpoint_tb;
	import slcm_pkg::*;

	typedef logic signed [383:0] wide_t;

	typedef struct {
		crd_t ap[3];
		crd_t ad[3];
		crd_t bp[3];
		crd_t bd[3];
	} pair_t;

	typedef struct {
		crd_t       m[3];
		logic [1:0] st;
	} mid_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic line_valid, line_stall, mid_valid, mid_stall;
	crd_t mid_x, mid_y, mid_z;
	logic [1:0] status;
	pair_t cur;

	pair_t pending_pairs[$];
	mid_t  expected_mids[$];
	int    errors = 0, n_sent = 0, n_got = 0, gap = 0, hold = 0, idle_cycles = 0;
	int    n_ok = 0, n_degen = 0, n_sat = 0;
	bit    long_hold_done = 0;

	always #5 clk = ~clk;

	skew_line_closest_midpoint u_top (
		.clk(clk), .arst_n(arst_n),
		.line_valid(line_valid), .line_stall(line_stall),
		.line_a_point_x(cur.ap[0]), .line_a_point_y(cur.ap[1]), .line_a_point_z(cur.ap[2]),
		.line_a_dir_x(cur.ad[0]), .line_a_dir_y(cur.ad[1]), .line_a_dir_z(cur.ad[2]),
		.line_b_point_x(cur.bp[0]), .line_b_point_y(cur.bp[1]), .line_b_point_z(cur.bp[2]),
		.line_b_dir_x(cur.bd[0]), .line_b_dir_y(cur.bd[1]), .line_b_dir_z(cur.bd[2]),
		.mid_valid(mid_valid), .mid_stall(mid_stall),
		.mid_x(mid_x), .mid_y(mid_y), .mid_z(mid_z), .status(status)
	);

	// mid = A + (2*((d x b).n)*a + (d.n)*n) / (2*(n.n)), rounded half away from zero
	function automatic mid_t closest_midpoint(pair_t it);
		wide_t pa[3], da[3], db[3], d[3], n[3], m[3];
		wide_t s, p, nn, num, mag, q, r;
		mid_t res;
		int i, j;
		s = 0; p = 0; nn = 0;
		res.st = ST_OK;
		for (int k = 0; k < 3; k++) begin
			pa[k] = it.ap[k];
			da[k] = it.ad[k];
			db[k] = it.bd[k];
			d[k] = wide_t'(it.bp[k]) - pa[k];
		end
		for (int k = 0; k < 3; k++) begin
			i = (k + 1) % 3;
			j = (k + 2) % 3;
			n[k] = da[i] * db[j] - da[j] * db[i];
			m[k] = d[i] * db[j] - d[j] * db[i];
		end
		for (int k = 0; k < 3; k++) begin
			s += m[k] * n[k];
			p += d[k] * n[k];
			nn += n[k] * n[k];
		end
		if (nn == 0) begin
			res.m = '{default: '0};
			res.st = ST_DEGEN;
			return res;
		end
		for (int k = 0; k < 3; k++) begin
			num = 2 * s * da[k] + p * n[k];
			mag = (num < 0) ? -num : num;
			q = (2 * mag + 2 * nn) / (4 * nn);
			if (num < 0) q = -q;
			r = pa[k] + q;
			if (r > R_MAX) begin
				r = R_MAX;
				res.st = ST_SAT;
			end else if (r < R_MIN) begin
				r = R_MIN;
				res.st = ST_SAT;
			end
			res.m[k] = r[31:0];
		end
		return res;
	endfunction

	function automatic crd_t rnd_crd(int sel);
		case (sel)
			0: return crd_t'($urandom);
			1: return crd_t'($urandom_range(0, 32'h3fffff)) - 32'sh200000;
			default: return crd_t'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
		endcase
	endfunction

	function automatic pair_t rnd_pair();
		pair_t it;
		int kind, sel, f;
		kind = $urandom_range(0, 9);
		sel = $urandom_range(0, 2);
		for (int k = 0; k < 3; k++) begin
			it.ap[k] = rnd_crd(sel);
			it.bp[k] = rnd_crd(sel);
			it.ad[k] = rnd_crd($urandom_range(0, 2));
			it.bd[k] = rnd_crd($urandom_range(0, 2));
		end
		f = $urandom_range(1, 4);
		if (kind == 0) begin
			for (int k = 0; k < 3; k++) begin
				it.ad[k] = crd_t'($urandom_range(0, 2047)) - 1024;
				it.bd[k] = it.ad[k] * (($urandom_range(0, 1) != 0) ? f : -f);
			end
		end else if (kind == 1) begin
			if ($urandom_range(0, 1) != 0) it.ad = '{default: '0};
			else it.bd = '{default: '0};
		end
		return it;
	endfunction

	function automatic pair_t mk_pair(crd_t a0, a1, a2, u0, u1, u2, c0, c1, c2, v0, v1, v2);
		pair_t it;
		it.ap = '{a0, a1, a2}; it.ad = '{u0, u1, u2};
		it.bp = '{c0, c1, c2}; it.bd = '{v0, v1, v2};
		return it;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid <= 1'b0;
			cur <= mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
			gap <= 0;
		end else begin
			if (line_valid && !line_stall) begin
				expected_mids.push_back(closest_midpoint(cur));
				n_sent++;
			end
			if (!(line_valid && line_stall)) begin
				if (gap > 0) begin
					gap <= gap - 1;
					line_valid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					cur <= pending_pairs.pop_front();
					line_valid <= 1'b1;
					gap <= (n_sent % 90 < 30) ? 0 : $urandom_range(0, 9);
				end else begin
					line_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		int h;
		mid_t e;
		if (!arst_n) begin
			mid_stall <= 1'b0;
			hold <= 0;
		end else begin
			h = hold;
			if (mid_valid && !mid_stall) begin
				n_got++;
				if (expected_mids.size() == 0) begin
					$error("word with no expectation: %h %h %h st %0d", mid_x, mid_y, mid_z,
						status);
					errors++;
				end else begin
					e = expected_mids.pop_front();
					if (mid_x !== e.m[0]) begin
						$error("mid_x exp %h got %h", e.m[0], mid_x); errors++;
					end
					if (mid_y !== e.m[1]) begin
						$error("mid_y exp %h got %h", e.m[1], mid_y); errors++;
					end
					if (mid_z !== e.m[2]) begin
						$error("mid_z exp %h got %h", e.m[2], mid_z); errors++;
					end
					if (status !== e.st) begin
						$error("status exp %0d got %0d", e.st, status); errors++;
					end
				end
				case (status)
					ST_OK:    n_ok++;
					ST_DEGEN: n_degen++;
					default:  n_sat++;
				endcase
				h = (n_got % 70 < 25) ? 0 : $urandom_range(0, 9);
				if (n_got == 250 && !long_hold_done) begin
					h = 300;
					long_hold_done = 1;
				end
			end else if (h > 0) begin
				h--;
			end
			hold <= h;
			mid_stall <= (h > 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((line_valid && !line_stall) || (mid_valid && !mid_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 2000) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		pending_pairs.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_pairs.push_back(mk_pair(0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h20000,
			0, 32'h10000, 0));
		pending_pairs.push_back(mk_pair(32'h8000, -32'h8000, 5, 0, 0, 32'h10000,
			32'h30000, 7, -9, 32'h10000, 32'h10000, 0));
		pending_pairs.push_back(mk_pair(1, 2, 3, 32'h10000, 32'h20000, 32'h30000,
			4, 5, 6, -32'h20000, -32'h40000, -32'h60000));
		pending_pairs.push_back(mk_pair(1, 2, 3, 0, 0, 0, 4, 5, 6, 1, 2, 3));
		pending_pairs.push_back(mk_pair(1, 2, 3, 1, 2, 3, 4, 5, 6, 0, 0, 0));
		pending_pairs.push_back(mk_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0,
			32'sh7fffffff, 0));
		pending_pairs.push_back(mk_pair(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
		pending_pairs.push_back(mk_pair(32'sh7fff0000, 0, 0, 0, 32'h10000, 0,
			0, 0, 32'h10000, 32'h10000, 0, 0));
		pending_pairs.push_back(mk_pair(32'sh80000000, 0, 0, 0, 32'h10000, 0,
			-32'h10000, 0, 0, 0, 0, 32'h10000));
		pending_pairs.push_back(mk_pair(0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 1, 0));
		pending_pairs.push_back(mk_pair(0, 0, 0, 3, 0, 0, 0, 1, 1, 0, 3, 0));
		pending_pairs.push_back(mk_pair(-1, -1, -1, -32'sh7fffffff, 32'sh7fffffff, 3,
			-1, 1, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000));
		wait (pending_pairs.size() == 0 && !line_valid && expected_mids.size() == 0);
		for (int k = 0; k < 550; k++) pending_pairs.push_back(rnd_pair());
		wait (pending_pairs.size() == 0 && !line_valid && expected_mids.size() == 0);
		repeat (LAT + 10) @(posedge clk);
		$display("%0d line pairs sent, %0d midpoints checked", n_sent, n_got);
		$display("ok %0d, parallel or zero direction %0d, saturated %0d",
			n_ok, n_degen, n_sat);
		if (errors == 0 && expected_mids.size() == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
